### rtl/core/bounded_ordered_list_store_macros.svh
// Assertion macros for the files that check their own behavior.
`ifndef BOUNDED_ORDERED_LIST_STORE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_STORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BOLS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BOLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bols_pkg.sv
`default_nettype none

package bols_pkg;

    localparam int CAPACITY_DEF = 16;

    typedef logic [2:0] t_cmd;

    localparam t_cmd CMD_APPEND  = 3'd0;
    localparam t_cmd CMD_PREPEND = 3'd1;
    localparam t_cmd CMD_INSERT  = 3'd2;
    localparam t_cmd CMD_FIND    = 3'd3;
    localparam t_cmd CMD_REMOVE  = 3'd4;
    localparam t_cmd CMD_READ    = 3'd5;

    typedef logic [1:0] t_status;

    localparam t_status STAT_OK   = 2'd0;
    localparam t_status STAT_MISS = 2'd1;
    localparam t_status STAT_FULL = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_ctrl;

endpackage

`default_nettype wire

### rtl/core/bols_ctrl.sv
`default_nettype none

module bols_ctrl
    import bols_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  wire      i_out_ready,
    output t_dp_ctrl o_dp_ctrl
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_dp_ctrl.capture = 1'b0;
        o_dp_ctrl.execute = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready        = 1'b1;
                o_dp_ctrl.capture = i_in_valid;
            end
            S_EXEC: begin
                o_dp_ctrl.execute = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_dp_ctrl.execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### rtl/core/bols_dp.sv
`default_nettype none

module bols_dp
    import bols_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_dp_ctrl           i_dp_ctrl,
    input  wire  [2:0]         i_cmd,
    input  wire  signed [31:0] i_value,
    input  wire  [3:0]         i_position,
    output logic [1:0]         o_status,
    output logic               o_found,
    output logic [4:0]         o_element_count,
    output logic signed [31:0] o_read_value
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = (CW > 4) ? CW : 4;
    localparam int CXW  = (CW > 5) ? CW : 5;
    localparam int RD_N = (CAPACITY < 16) ? CAPACITY : 16;

    logic signed [31:0] r_cell [CAPACITY];
    logic signed [31:0] n_cell [CAPACITY];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;

    t_cmd               r_cmd;
    logic signed [31:0] r_value;
    logic [3:0]         r_pos;
    logic [CAPACITY-1:0] r_match;

    t_status            r_status;
    logic               r_found;
    logic signed [31:0] r_rd;

    t_status            status;
    logic               found;
    logic signed [31:0] rd;
    logic               ins_ok;
    logic [PW-1:0]      ins_at;
    logic               do_remove;
    logic               full;
    logic               any_match;
    logic [PW-1:0]      count_x;
    logic [PW-1:0]      pos_x;
    logic signed [31:0] rd_sel;
    logic [CAPACITY-1:0] low_mask;
    logic [CAPACITY-1:0] shift_up;
    logic [CXW-1:0]     count_out;

    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.capture) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
            r_pos   <= i_position;
            for (int i = 0; i < CAPACITY; i++) begin
                r_match[i] <= (r_cell[i] == i_value) && (CW'(i) < r_count);
            end
        end
    end

    assign full      = (r_count == CW'(CAPACITY));
    assign any_match = |r_match;
    assign count_x   = PW'(r_count);
    assign pos_x     = PW'(r_pos);
    assign low_mask  = r_match ^ (r_match - CAPACITY'(1));
    assign shift_up  = ~(low_mask >> 1);

    always_comb begin
        rd_sel = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (r_pos == 4'(i)) begin
                rd_sel = r_cell[i];
            end
        end
    end

    always_comb begin
        status    = STAT_OK;
        found     = 1'b0;
        rd        = '0;
        ins_ok    = 1'b0;
        ins_at    = '0;
        do_remove = 1'b0;
        case (r_cmd)
            CMD_APPEND: begin
                if (full) begin
                    status = STAT_FULL;
                end else begin
                    ins_ok = 1'b1;
                    ins_at = count_x;
                end
            end
            CMD_PREPEND: begin
                if (full) begin
                    status = STAT_FULL;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            CMD_INSERT: begin
                if (full) begin
                    status = STAT_FULL;
                end else if (pos_x >= count_x) begin
                    status = STAT_MISS;
                end else begin
                    ins_ok = 1'b1;
                    ins_at = pos_x;
                end
            end
            CMD_FIND: begin
                if (any_match) begin
                    found = 1'b1;
                end else begin
                    status = STAT_MISS;
                end
            end
            CMD_REMOVE: begin
                if (any_match) begin
                    found     = 1'b1;
                    do_remove = 1'b1;
                end else begin
                    status = STAT_MISS;
                end
            end
            CMD_READ: begin
                if (pos_x >= count_x) begin
                    status = STAT_MISS;
                end else begin
                    rd = rd_sel;
                end
            end
            default: status = STAT_MISS;
        endcase
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
        end
        if (ins_ok) begin
            if (ins_at == '0) begin
                n_cell[0] = r_value;
            end
            for (int i = 1; i < CAPACITY; i++) begin
                if (PW'(i) == ins_at) begin
                    n_cell[i] = r_value;
                end else if (PW'(i) > ins_at) begin
                    n_cell[i] = r_cell[i-1];
                end
            end
        end else if (do_remove) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (shift_up[i]) begin
                    n_cell[i] = r_cell[i+1];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (do_remove) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.execute) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_cell[i] <= n_cell[i];
            end
            r_status <= status;
            r_found  <= found;
            r_rd     <= rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_ctrl.execute) begin
            r_count <= n_count;
        end
    end

    assign count_out       = CXW'(r_count);
    assign o_status        = r_status;
    assign o_found         = r_found;
    assign o_element_count = count_out[4:0];
    assign o_read_value    = r_rd;

endmodule

`default_nettype wire

### rtl/core/bounded_ordered_list_store.sv
// Ordered list of up to CAPACITY signed 32-bit values, head at index 0.
// Commands arrive on the s_axis channel, one word per command: the command
// code in tuser, the value and the position in tdata. Each command yields
// exactly one result word on the m_axis channel: status and found in tuser,
// the element count after the command and the read value in tdata.
// A command is captured first, when all held entries are compared with its
// value at once, and then carried out in its execute step, when the entries
// shift as one cell row and the result register is loaded. No new command is
// taken while one is in its execute step. The result register holds a
// finished word while the receiver stalls, and one further command may be
// accepted meanwhile; it then waits in its execute step until the held word
// is taken.
// Reset empties the list and drops any pending result at once; the
// entries themselves are not cleared, since no command reads beyond the
// current count.
`default_nettype none

`include "bounded_ordered_list_store_macros.svh"

module bounded_ordered_list_store
    import bols_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,  // value [31:0], position [35:32], zeros [39:36]
    input  wire  [2:0]  s_axis_tuser,  // cmd [2:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,  // element_count [4:0], read_value [36:5], zeros [39:37]
    output logic [2:0]  m_axis_tuser   // status [1:0], found [2]
);

    t_dp_ctrl           dp_ctrl;
    logic [1:0]         status;
    logic               found;
    logic [4:0]         element_count;
    logic signed [31:0] read_value;

    bols_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_dp_ctrl   (dp_ctrl)
    );

    bols_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_ctrl       (dp_ctrl),
        .i_cmd           (s_axis_tuser),
        .i_value         (s_axis_tdata[31:0]),
        .i_position      (s_axis_tdata[35:32]),
        .o_status        (status),
        .o_found         (found),
        .o_element_count (element_count),
        .o_read_value    (read_value)
    );

    assign m_axis_tdata = {3'b000, read_value, element_count};
    assign m_axis_tuser = {found, status};

    `BOLS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "command accepted while previous one still executing")
    `BOLS_ASSERT_SAME(a_found_is_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == STAT_OK, "found reported with a failing status")
    `BOLS_ASSERT_SAME(a_full_at_capacity, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[1:0] == STAT_FULL), m_axis_tdata[4:0] == 5'(CAPACITY), "full reported below capacity")
    `BOLS_ASSERT_SAME(a_count_bounded, i_clk, i_rst_n, m_axis_tvalid, 32'(m_axis_tdata[4:0]) <= 32'(CAPACITY), "element count above capacity")

endmodule

`default_nettype wire
